/* design/symbol_run_length_encoder_assert.svh */
// assertion macros for the symbol run-length encoder
// no dependencies; included by the top level
`ifndef SYMBOL_RUN_LENGTH_ENCODER_ASSERT_SVH
`define SYMBOL_RUN_LENGTH_ENCODER_ASSERT_SVH

// same-cycle implication
`define SRLE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/srle_pkg.sv */
// shared constants, types and helpers of the symbol run-length encoder
// no dependencies
`default_nettype none

package srle_pkg;

   localparam int COUNT_WIDTH     = 40;
   localparam int MAX_CHUNK       = 31;
   localparam int NUM_SYMBOLS     = 6;
   localparam int SYMBOL_WIDTH    = 3;
   localparam int LENGTH_WIDTH    = 8;
   localparam int CHUNK_WIDTH     = 5;
   localparam int CODE_WIDTH      = CHUNK_WIDTH + SYMBOL_WIDTH;
   localparam int WORK_WIDTH      = $clog2(MAX_CHUNK + (1 << LENGTH_WIDTH));
   localparam int SYM_INDEX_WIDTH = $clog2(NUM_SYMBOLS);

   localparam logic [SYMBOL_WIDTH-1:0] NO_SYMBOL  = SYMBOL_WIDTH'(7);
   localparam logic [CODE_WIDTH-1:0]   END_MARKER = CODE_WIDTH'(7);
   localparam logic                    CMD_APPEND   = 1'b0;
   localparam logic                    CMD_FINALIZE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FLUSH,
      ST_EXCESS,
      ST_SUM,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic load;
      logic commit_work;
      logic emit_flush;
      logic emit_excess;
      logic sum_init;
      logic sum_step;
      logic emit_end;
      logic last;
   } dp_cmd_type;

   typedef struct packed {
      logic finalize;
      logic sym_valid;
      logic same_sym;
      logic pend_nonzero;
      logic work_gt_max;
      logic work_after_gt;
      logic sum_done;
      logic out_free;
   } dp_status_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/srle_if.sv */
// request and response channel interfaces of the symbol run-length encoder
// depends on srle_pkg
`default_nettype none

interface srle_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [srle_pkg::SYMBOL_WIDTH-1:0]   symbol;
   logic [srle_pkg::LENGTH_WIDTH-1:0]   run_length;

   modport source (output valid, command, symbol, run_length, input ready);
   modport sink   (input valid, command, symbol, run_length, output ready);
endinterface

interface srle_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [srle_pkg::CODE_WIDTH-1:0]    code_byte;
   logic [srle_pkg::COUNT_WIDTH-1:0]   symbol_total;
   logic                               last;

   modport source (output valid, code_byte, symbol_total, last, input ready);
   modport sink   (input valid, code_byte, symbol_total, last, output ready);
endinterface

`default_nettype wire

/* design/srle_ctrl.sv */
// controller state machine of the symbol run-length encoder
// depends on srle_pkg
`default_nettype none

module srle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire srle_pkg::dp_status_type status,
   output srle_pkg::dp_cmd_type         cmd
);

   srle_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srle_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = srle_pkg::ST_DECIDE;
            end
         end
         srle_pkg::ST_DECIDE: begin
            if (status.finalize) begin
               state_in = status.pend_nonzero ? srle_pkg::ST_FLUSH : srle_pkg::ST_SUM;
            end else if (!status.sym_valid) begin
               state_in = srle_pkg::ST_IDLE;
            end else if (!status.same_sym && status.pend_nonzero) begin
               state_in = srle_pkg::ST_FLUSH;
            end else if (status.work_gt_max) begin
               state_in = srle_pkg::ST_EXCESS;
            end else begin
               state_in = srle_pkg::ST_IDLE;
            end
         end
         srle_pkg::ST_FLUSH: begin
            if (status.out_free) begin
               state_in = status.finalize ? srle_pkg::ST_SUM : srle_pkg::ST_EXCESS;
            end
         end
         srle_pkg::ST_EXCESS: begin
            if (!status.work_gt_max) begin
               state_in = srle_pkg::ST_IDLE;
            end
         end
         srle_pkg::ST_SUM: begin
            if (status.sum_done) begin
               state_in = srle_pkg::ST_FINAL;
            end
         end
         srle_pkg::ST_FINAL: begin
            if (status.out_free) begin
               state_in = srle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srle_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         srle_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         srle_pkg::ST_DECIDE: begin
            if (status.finalize) begin
               cmd.sum_init = 1'b1;
            end else if (status.sym_valid && !(!status.same_sym && status.pend_nonzero)
                         && !status.work_gt_max) begin
               cmd.commit_work = 1'b1;
            end
         end
         srle_pkg::ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit_flush = 1'b1;
               cmd.last       = !status.finalize && !status.work_gt_max;
            end
         end
         srle_pkg::ST_EXCESS: begin
            if (status.work_gt_max) begin
               if (status.out_free) begin
                  cmd.emit_excess = 1'b1;
                  cmd.last        = !status.work_after_gt;
               end
            end else begin
               cmd.commit_work = 1'b1;
            end
         end
         srle_pkg::ST_SUM: begin
            cmd.sum_step = 1'b1;
         end
         srle_pkg::ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit_end = 1'b1;
               cmd.last     = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/srle_datapath.sv */
// datapath of the symbol run-length encoder: pending run, totals, output register
// depends on srle_pkg and the channel interfaces
`default_nettype none

module srle_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire srle_pkg::dp_cmd_type cmd,
   output srle_pkg::dp_status_type   status,
   srle_req_if.sink                  req,
   srle_rsp_if.source                rsp
);

   logic [srle_pkg::SYMBOL_WIDTH-1:0]    pend_sym_ff, pend_sym_in;
   logic [srle_pkg::CHUNK_WIDTH-1:0]     pend_len_ff, pend_len_in;
   logic [srle_pkg::SYMBOL_WIDTH-1:0]    work_sym_ff, work_sym_in;
   logic [srle_pkg::WORK_WIDTH-1:0]      work_len_ff, work_len_in;
   logic                                 fin_ff, fin_in;
   logic                                 same_ff, same_in;
   logic [srle_pkg::COUNT_WIDTH-1:0]     counts_ff [srle_pkg::NUM_SYMBOLS];
   logic [srle_pkg::COUNT_WIDTH-1:0]     counts_in [srle_pkg::NUM_SYMBOLS];
   logic [srle_pkg::COUNT_WIDTH-1:0]     sum_ff, sum_in;
   logic [srle_pkg::SYM_INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [srle_pkg::CODE_WIDTH-1:0]      rsp_code_ff, rsp_code_in;
   logic [srle_pkg::COUNT_WIDTH-1:0]     rsp_total_ff, rsp_total_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic                                 emit_chunk;
   logic                                 emit_any;
   logic [srle_pkg::SYMBOL_WIDTH-1:0]    chunk_sym;
   logic [srle_pkg::CHUNK_WIDTH-1:0]     chunk_len;
   logic [srle_pkg::SYM_INDEX_WIDTH-1:0] rd_idx;
   logic [srle_pkg::COUNT_WIDTH-1:0]     rd_count;
   logic [srle_pkg::COUNT_WIDTH-1:0]     chunk_total;

   // one shared read port on the totals
   assign emit_chunk  = cmd.emit_flush || cmd.emit_excess;
   assign emit_any    = emit_chunk || cmd.emit_end;
   assign chunk_sym   = cmd.emit_flush ? pend_sym_ff : work_sym_ff;
   assign chunk_len   = cmd.emit_flush ? pend_len_ff : srle_pkg::CHUNK_WIDTH'(srle_pkg::MAX_CHUNK);
   assign rd_idx      = cmd.sum_step ? idx_ff : chunk_sym[srle_pkg::SYM_INDEX_WIDTH-1:0];
   assign rd_count    = counts_ff[rd_idx];
   assign chunk_total = srle_pkg::sat_add(rd_count, srle_pkg::COUNT_WIDTH'(chunk_len));

   always_comb begin
      pend_sym_in  = pend_sym_ff;
      pend_len_in  = pend_len_ff;
      work_sym_in  = work_sym_ff;
      work_len_in  = work_len_ff;
      fin_in       = fin_ff;
      same_in      = same_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      counts_in    = counts_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;

      // capture the item; a run of the pending symbol merges at once
      if (cmd.load) begin
         fin_in      = (req.command == srle_pkg::CMD_FINALIZE);
         same_in     = (req.symbol == pend_sym_ff);
         work_sym_in = req.symbol;
         if (req.symbol == pend_sym_ff) begin
            work_len_in = srle_pkg::WORK_WIDTH'(pend_len_ff)
                        + srle_pkg::WORK_WIDTH'(req.run_length);
         end else begin
            work_len_in = srle_pkg::WORK_WIDTH'(req.run_length);
         end
      end

      if (cmd.emit_excess) begin
         work_len_in = work_len_ff - srle_pkg::WORK_WIDTH'(srle_pkg::MAX_CHUNK);
      end

      if (cmd.commit_work) begin
         pend_sym_in = work_sym_ff;
         pend_len_in = work_len_ff[srle_pkg::CHUNK_WIDTH-1:0];
      end

      if (emit_chunk) begin
         counts_in[chunk_sym[srle_pkg::SYM_INDEX_WIDTH-1:0]] = chunk_total;
      end

      if (cmd.sum_init) begin
         sum_in = '0;
         idx_in = '0;
      end else if (cmd.sum_step) begin
         sum_in = srle_pkg::sat_add(sum_ff, rd_count);
         idx_in = idx_ff + srle_pkg::SYM_INDEX_WIDTH'(1);
      end

      // end marker closes the stream and clears the pending run and all totals
      if (cmd.emit_end) begin
         pend_sym_in = srle_pkg::NO_SYMBOL;
         pend_len_in = '0;
         for (int i = 0; i < srle_pkg::NUM_SYMBOLS; i++) begin
            counts_in[i] = '0;
         end
      end

      if (emit_any) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = cmd.emit_end ? srle_pkg::END_MARKER : {chunk_len, chunk_sym};
         rsp_total_in = cmd.emit_end ? sum_ff : chunk_total;
         rsp_last_in  = cmd.last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_sym_ff  <= srle_pkg::NO_SYMBOL;
         pend_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < srle_pkg::NUM_SYMBOLS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         pend_sym_ff  <= pend_sym_in;
         pend_len_ff  <= pend_len_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      work_sym_ff  <= work_sym_in;
      work_len_ff  <= work_len_in;
      fin_ff       <= fin_in;
      same_ff      <= same_in;
      sum_ff       <= sum_in;
      idx_ff       <= idx_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.finalize      = fin_ff;
   assign status.sym_valid     = (work_sym_ff < srle_pkg::SYMBOL_WIDTH'(srle_pkg::NUM_SYMBOLS));
   assign status.same_sym      = same_ff;
   assign status.pend_nonzero  = (pend_len_ff != '0);
   assign status.work_gt_max   = (work_len_ff > srle_pkg::WORK_WIDTH'(srle_pkg::MAX_CHUNK));
   assign status.work_after_gt = (work_len_ff > srle_pkg::WORK_WIDTH'(2 * srle_pkg::MAX_CHUNK));
   assign status.sum_done      = (idx_ff == srle_pkg::SYM_INDEX_WIDTH'(srle_pkg::NUM_SYMBOLS - 1));
   assign status.out_free      = !rsp_valid_ff || rsp.ready;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.code_byte    = rsp_code_ff;
   assign rsp.symbol_total = rsp_total_ff;
   assign rsp.last         = rsp_last_ff;

endmodule

`default_nettype wire

/* design/symbol_run_length_encoder.sv */
// symbol run-length encoder, top level: controller plus datapath
// an append may emit a flush byte for the pending run and excess bytes of full chunks;
//   a finalize flushes the pending run, sums the totals of all symbols, then emits the end marker
// the single chunk unit does one saturating add per byte; rsp stalls hold the sequencer
// reset: synchronous, active high; clears the pending run, all totals and the output valid flag
`default_nettype none
`include "symbol_run_length_encoder_assert.svh"

module symbol_run_length_encoder (
   input wire logic   clock,
   input wire logic   reset,
   srle_req_if.sink   req_bus,
   srle_rsp_if.source rsp_bus
);

   // command and status between the two halves
   srle_pkg::dp_cmd_type    dp_cmd;
   srle_pkg::dp_status_type dp_status;
   logic                    ctrl_ready;

   // sequencer: one item at a time, one code byte per cycle at most
   srle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctrl_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // pending run, per-symbol totals and the registered output item
   srle_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (dp_cmd),
      .status (dp_status),
      .req    (req_bus),
      .rsp    (rsp_bus)
   );

   // item taken only while the sequencer is idle
   assign req_bus.ready = ctrl_ready;

   // a byte is only written into a free output register
   `SRLE_ASSERT_IMPLIES(a_emit_into_free, clock, reset,
      dp_cmd.emit_flush || dp_cmd.emit_excess || dp_cmd.emit_end,
      dp_status.out_free, "code byte written over an untaken item")

   // at most one source drives the output register
   `SRLE_ASSERT_IMPLIES(a_one_emit, clock, reset, 1'b1,
      $onehot0({dp_cmd.emit_flush, dp_cmd.emit_excess, dp_cmd.emit_end}),
      "more than one code byte source in a cycle")

   // end marker leaves no pending run behind
   `SRLE_ASSERT_NEXT(a_end_clears_run, clock, reset, dp_cmd.emit_end,
      !dp_status.pend_nonzero, "pending run survived the end marker")

   // a captured item blocks the input until it is worked off
   `SRLE_ASSERT_NEXT(a_busy_after_load, clock, reset, dp_cmd.load,
      !ctrl_ready, "input ready right after an item was taken")

endmodule

`default_nettype wire
